@@ design/box_mean_3x3_edge_aware_assert.svh @@
// assertion macros for the 3x3 mean filter, empty when synthesized
`ifndef BOX_MEAN_3X3_EDGE_AWARE_ASSERT_SVH
`define BOX_MEAN_3X3_EDGE_AWARE_ASSERT_SVH
`ifndef SYNTHESIS
`define BM_ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("bm3x3 check failed: same-cycle implication");
`define BM_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bm3x3 check failed: next-cycle implication");
`else
`define BM_ASSERT_IMPLY(label, cond, expr)
`define BM_ASSERT_NEXT(label, cond, expr)
`endif
`endif

@@ design/bm3x3_pkg.sv @@
// constants, types and the divide-by-count reciprocal table of the 3x3 mean filter
package bm3x3_pkg;

    localparam int unsigned MAX_COLS   = 1024;
    localparam int unsigned MAX_ROWS   = 4096;
    localparam int unsigned PIXEL_BITS = 8;

    localparam int unsigned CFG_ROWS_W = 13;
    localparam int unsigned CFG_COLS_W = 11;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
    localparam int unsigned COL_W      = $clog2(MAX_COLS);
    localparam int unsigned GAP_W      = $clog2(MAX_COLS + 2);
    localparam int unsigned RING_AW    = $clog2(2 * MAX_COLS);
    localparam int unsigned RING_DEPTH = 2 ** RING_AW;

    localparam int unsigned SUM_W      = $clog2(9 * (2 ** PIXEL_BITS - 1) + 1);
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned MEAN_W     = 16;
    localparam int unsigned DIVIDEND_W = SUM_W + FRAC_BITS;
    localparam int unsigned DIV_SHIFT  = DIVIDEND_W + CNT_W;
    localparam int unsigned RECIP_W    = DIV_SHIFT + 1;
    localparam int unsigned PROD_W     = DIVIDEND_W + RECIP_W;

    // ceil(2^DIV_SHIFT / d) gives an exact quotient for every dividend in range
    localparam longint unsigned DIV_ONE = 64'd1 << DIV_SHIFT;
    localparam longint unsigned RECIP_3 = (DIV_ONE + 2) / 3;
    localparam longint unsigned RECIP_6 = (DIV_ONE + 5) / 6;
    localparam longint unsigned RECIP_9 = (DIV_ONE + 8) / 9;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } bm_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } bm_mask_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            CNT_W'(1): r = RECIP_W'(DIV_ONE);
            CNT_W'(2): r = RECIP_W'(DIV_ONE >> 1);
            CNT_W'(3): r = RECIP_W'(RECIP_3);
            CNT_W'(4): r = RECIP_W'(DIV_ONE >> 2);
            CNT_W'(6): r = RECIP_W'(RECIP_6);
            CNT_W'(9): r = RECIP_W'(RECIP_9);
            default:   r = RECIP_W'(DIV_ONE);
        endcase
        return r;
    endfunction

endpackage

@@ design/box_mean_3x3_edge_aware.sv @@
// 3x3 edge-aware box mean filter, top level. Pixels enter in raster order, one
// transaction per clock, and every pushed position writes a 2048 x 8 line ring
// while its two ports read the pixels one and two rows above; the third row comes
// straight from the input. The 3x3 window slides one column per push and the
// sum of its in-frame pixels is divided by their count with a reciprocal
// multiply. Sustained rate is one item per clock; a result passes stage 1, stage 2
// and the output register after the transaction that causes it, and a stall on
// the result side holds the pipeline and then the input. Once the last pixel of
// a single-row frame has arrived the block pushes a padding column and accepts
// nothing while it does so. The line ring needs no clearing after reset.
`include "box_mean_3x3_edge_aware_assert.svh"

module box_mean_3x3_edge_aware
    import bm3x3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  mode,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [MEAN_W-1:0]     mean_value,
    output logic                  frame_last
);

    // frame geometry, stored as size minus one after clamping
    logic [ROW_W-1:0] rows_m1_reg, rows_m1_next;
    logic [COL_W-1:0] cols_m1_reg, cols_m1_next;

    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic             all_in_reg, all_in_next;
    logic [GAP_W-1:0] gap_reg, gap_next;
    logic [RING_AW-1:0] wr_reg, wr_next;

    logic [PIXEL_BITS-1:0] line_mem [RING_DEPTH];

    // stage 1: column read from the ring
    logic                  s1_valid_reg;
    logic                  s1_emit_reg;
    logic                  s1_last_reg;
    bm_mask_t              s1_mask_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [PIXEL_BITS-1:0] rd_mid_reg;
    logic [PIXEL_BITS-1:0] rd_top_reg;

    logic [PIXEL_BITS-1:0] win_reg [3][3];

    // stage 2: masked sum and count
    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [CNT_W-1:0] s2_cnt_reg;
    logic             s2_last_reg;

    logic              result_valid_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic              last_reg;

    logic               out_free, s2_ready, s2_go, s1_go, s1_ready;
    logic [GAP_W-1:0]   lag_full;
    logic               pad_req, push_pad, accept;
    logic               take_pixel, take_drain, push, emit, out_last;
    logic               cfg_restart;
    bm_mask_t           mask_now;
    logic [RING_AW-1:0] cols_ring, addr_mid, addr_top;
    logic [PIXEL_BITS-1:0] wr_data;

    logic [CFG_ROWS_W-1:0] rows_raw;
    logic [CFG_COLS_W-1:0] cols_raw;
    logic [ROW_W-1:0]      rows_m1_cfg;
    logic [COL_W-1:0]      cols_m1_cfg;

    logic [PIXEL_BITS-1:0] win_shift [3][3];
    logic [SUM_W-1:0]      s1_sum;
    logic [1:0]            rows_n, cols_n;
    logic [CNT_W-1:0]      s1_cnt;

    logic [DIVIDEND_W-1:0] dividend;
    logic [PROD_W-1:0]     product;

    // handshake chain from the output register back to the input
    assign out_free = !result_valid_reg || result_ready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s2_go    = s2_valid_reg && out_free;
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || s2_ready);
    assign s1_ready = !s1_valid_reg || s1_go;

    assign lag_full = GAP_W'(cols_m1_reg) + GAP_W'(2);
    // a frame shorter than the full lag gets one padding column before draining
    assign pad_req  = all_in_reg && (gap_reg != lag_full);
    assign push_pad = pad_req && s1_ready;

    assign item_ready = s1_ready && !pad_req;
    assign accept     = item_valid && item_ready;
    assign take_pixel = accept && (bm_mode_t'(mode) == MODE_PIXEL) && !all_in_reg;
    assign take_drain = accept && (bm_mode_t'(mode) == MODE_DRAIN) && all_in_reg;
    assign push       = take_pixel || take_drain || push_pad;
    assign emit       = (take_pixel && (gap_reg == lag_full)) || take_drain;
    assign out_last   = (out_row_reg == rows_m1_reg) && (out_col_reg == cols_m1_reg);

    assign mask_now.top_ok   = (out_row_reg != '0);
    assign mask_now.bot_ok   = (out_row_reg != rows_m1_reg);
    assign mask_now.left_ok  = (out_col_reg != '0);
    assign mask_now.right_ok = (out_col_reg != cols_m1_reg);

    assign cols_ring = RING_AW'(cols_m1_reg) + RING_AW'(1);
    assign addr_mid  = wr_reg - cols_ring;
    assign addr_top  = wr_reg - RING_AW'(cols_ring << 1);
    assign wr_data   = push_pad ? '0 : pixel_value;

    assign cfg_restart = cfg_we &&
                         ((cfg_index == REG_FRAME_ROWS) || (cfg_index == REG_FRAME_COLS));

    always_comb
    begin
        rows_raw = cfg_data[CFG_ROWS_W-1:0];
        cols_raw = cfg_data[CFG_COLS_W-1:0];
        if (rows_raw == '0)
        begin
            rows_m1_cfg = '0;
        end
        else if (rows_raw > CFG_ROWS_W'(MAX_ROWS))
        begin
            rows_m1_cfg = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            rows_m1_cfg = ROW_W'(rows_raw - CFG_ROWS_W'(1));
        end
        if (cols_raw == '0)
        begin
            cols_m1_cfg = '0;
        end
        else if (cols_raw > CFG_COLS_W'(MAX_COLS))
        begin
            cols_m1_cfg = COL_W'(MAX_COLS - 1);
        end
        else
        begin
            cols_m1_cfg = COL_W'(cols_raw - CFG_COLS_W'(1));
        end
    end

    always_comb
    begin
        rows_m1_next = rows_m1_reg;
        cols_m1_next = cols_m1_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        all_in_next  = all_in_reg;
        gap_next     = gap_reg;
        wr_next      = push ? wr_reg + RING_AW'(1) : wr_reg;
        if (cfg_restart)
        begin
            if (cfg_index == REG_FRAME_ROWS)
            begin
                rows_m1_next = rows_m1_cfg;
            end
            else
            begin
                cols_m1_next = cols_m1_cfg;
            end
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            all_in_next  = 1'b0;
            gap_next     = '0;
        end
        else
        begin
            if (take_pixel)
            begin
                if ((in_row_reg == rows_m1_reg) && (in_col_reg == cols_m1_reg))
                begin
                    all_in_next = 1'b1;
                end
                else if (in_col_reg == cols_m1_reg)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            if (push && !emit)
            begin
                gap_next = gap_reg + GAP_W'(1);
            end
            if (emit)
            begin
                if (out_last)
                begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                    all_in_next  = 1'b0;
                    gap_next     = '0;
                end
                else if (out_col_reg == cols_m1_reg)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m1_reg <= '0;
            cols_m1_reg <= '0;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            all_in_reg  <= 1'b0;
            gap_reg     <= '0;
            wr_reg      <= '0;
        end
        else
        begin
            rows_m1_reg <= rows_m1_next;
            cols_m1_reg <= cols_m1_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            all_in_reg  <= all_in_next;
            gap_reg     <= gap_next;
            wr_reg      <= wr_next;
        end
    end

    // line ring: read-first, so a read at the write address returns the old pixel
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            line_mem[wr_reg] <= wr_data;
            rd_mid_reg       <= line_mem[addr_mid];
            rd_top_reg       <= line_mem[addr_top];
            s1_pix_reg       <= wr_data;
            s1_mask_reg      <= mask_now;
            s1_last_reg      <= out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= push;
            s1_emit_reg  <= emit;
        end
    end

    // window after this column shifts in, masked sum and pixel count
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_shift[r][0] = win_reg[r][1];
            win_shift[r][1] = win_reg[r][2];
        end
        win_shift[0][2] = rd_top_reg;
        win_shift[1][2] = rd_mid_reg;
        win_shift[2][2] = s1_pix_reg;
        s1_sum = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (((r != 0) || s1_mask_reg.top_ok) && ((r != 2) || s1_mask_reg.bot_ok) &&
                    ((c != 0) || s1_mask_reg.left_ok) && ((c != 2) || s1_mask_reg.right_ok))
                begin
                    s1_sum = s1_sum + SUM_W'(win_shift[r][c]);
                end
            end
        end
        rows_n = 2'd1 + {1'b0, s1_mask_reg.top_ok} + {1'b0, s1_mask_reg.bot_ok};
        cols_n = 2'd1 + {1'b0, s1_mask_reg.left_ok} + {1'b0, s1_mask_reg.right_ok};
        s1_cnt = CNT_W'(rows_n) * CNT_W'(cols_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (s1_go)
        begin
            win_reg <= win_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_go && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_go && s1_emit_reg)
        begin
            s2_sum_reg  <= s1_sum;
            s2_cnt_reg  <= s1_cnt;
            s2_last_reg <= s1_last_reg;
        end
    end

    // (sum * 256 + count / 2) / count as a reciprocal multiply
    assign dividend = {s2_sum_reg, FRAC_BITS'(0)} + DIVIDEND_W'(s2_cnt_reg >> 1);
    assign product  = PROD_W'(dividend) * PROD_W'(recip_of(s2_cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            mean_reg <= product[DIV_SHIFT +: MEAN_W];
            last_reg <= s2_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign mean_value   = mean_reg;
    assign frame_last   = last_reg;

    `BM_ASSERT_IMPLY(a_gap_bounded, 1'b1, gap_reg <= lag_full)
    `BM_ASSERT_IMPLY(a_all_in_at_end, all_in_reg,
        (in_row_reg == rows_m1_reg) && (in_col_reg == cols_m1_reg))
    `BM_ASSERT_IMPLY(a_last_only_drained, emit && out_last, take_drain)
    `BM_ASSERT_NEXT(a_s1_holds_column, s1_valid_reg && !s1_go,
        $stable(rd_mid_reg) && $stable(rd_top_reg) && s1_valid_reg)

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the streaming 3x3 edge-aware box mean filter
module testbench;
    import bm3x3_pkg::*;

    localparam int IDLE_PCT       = 18;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int MAX_PRINTS     = 200;
    localparam int PIX_RING_LEN   = 2 * MAX_COLS + 3;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              last;
    } mean_rec_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_FRAME_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    logic                  mode         = MODE_PIXEL;
    logic [PIXEL_BITS-1:0] pixel_value  = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [MEAN_W-1:0]     mean_value;
    logic                  frame_last;

    // shadow of the filter: frame shape, pixels of the current frame, positions
    logic [CFG_ROWS_W-1:0] rows_reg = CFG_ROWS_W'(1);
    logic [CFG_COLS_W-1:0] cols_reg = CFG_COLS_W'(1);
    logic [PIXEL_BITS-1:0] pix_ring [PIX_RING_LEN];
    int                    px_in     = 0;
    bit                    px_all_in = 1'b0;
    int                    out_row   = 0;
    int                    out_col   = 0;
    mean_rec_t             expected_means [$];

    int error_count  = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    bit no_gaps      = 1'b0;

    box_mean_3x3_edge_aware u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .mean_value   (mean_value),
        .frame_last   (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int frame_height();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > MAX_ROWS)
            return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic int frame_width();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function automatic void restart_frame();
        px_in     = 0;
        px_all_in = 1'b0;
        out_row   = 0;
        out_col   = 0;
    endfunction

    // mean of the in-frame neighbours of the next output position
    function automatic void emit_mean();
        int        height;
        int        width;
        int        sum;
        int        cnt;
        int        r;
        int        c;
        int        dr;
        int        dc;
        mean_rec_t rec;
        height = frame_height();
        width  = frame_width();
        sum    = 0;
        cnt    = 0;
        for (dr = -1; dr <= 1; dr++)
            for (dc = -1; dc <= 1; dc++)
            begin
                r = out_row + dr;
                c = out_col + dc;
                if (r >= 0 && r < height && c >= 0 && c < width)
                begin
                    sum += pix_ring[(r * width + c) % PIX_RING_LEN];
                    cnt++;
                end
            end
        rec.mean = MEAN_W'((sum * 256 + cnt / 2) / cnt);
        rec.last = (out_row + 1 == height) && (out_col + 1 == width);
        expected_means.insert(expected_means.size(), rec);
        if (rec.last)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= width)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // returns 1 when the transaction does something, 0 when the filter ignores it
    function automatic bit predict_item(input bm_mode_t m, input logic [PIXEL_BITS-1:0] p);
        int height;
        int width;
        int n;
        int k;
        height = frame_height();
        width  = frame_width();
        if (m == MODE_DRAIN)
        begin
            if (!px_all_in)
                return 1'b0;
            emit_mean();
            return 1'b1;
        end
        if (px_all_in)
            return 1'b0;
        n = px_in;
        pix_ring[n % PIX_RING_LEN] = p;
        if (n + 1 >= height * width)
            px_all_in = 1'b1;
        else
            px_in++;
        k = out_row * width + out_col;
        if (n - k == width + 1)
            emit_mean();
        return 1'b1;
    endfunction

    task automatic log_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // starts and ends at a falling edge; valid is left high for the caller
    task automatic send_item(input bm_mode_t m, input logic [PIXEL_BITS-1:0] p);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        mode        <= m;
        pixel_value <= p;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent += predict_item(m, p);
        @(negedge clk);
    endtask

    task automatic pause_for_results();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_means.size() != 0);
    endtask

    task automatic wait_idle();
        pause_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_FRAME_ROWS)
            rows_reg = data;
        else
            cols_reg = data[CFG_COLS_W-1:0];
        restart_frame();
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(input bit harsh);
        if (harsh || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? {PIXEL_BITS{1'b1}} : '0;
        return PIXEL_BITS'($urandom);
    endfunction

    // pixels until the frame is in (or stop_at pixels), then drains until its last output
    task automatic run_frame(input int noise_pct, input bit harsh, input int stop_at);
        int sent_px;
        sent_px = 0;
        while (!px_all_in && sent_px != stop_at)
        begin
            // early drain, ignored
            if ($urandom_range(0, 99) < noise_pct)
                send_item(MODE_DRAIN, PIXEL_BITS'($urandom));
            send_item(MODE_PIXEL, pick_pixel(harsh));
            sent_px++;
        end
        if (sent_px == stop_at)
            return;
        while (px_all_in)
        begin
            // pixel while outputs are pending, ignored
            if ($urandom_range(0, 99) < noise_pct)
                send_item(MODE_PIXEL, PIXEL_BITS'($urandom));
            send_item(MODE_DRAIN, PIXEL_BITS'($urandom));
        end
        if ($urandom_range(0, 99) < noise_pct)
            repeat ($urandom_range(1, 3)) send_item(MODE_DRAIN, PIXEL_BITS'($urandom));
    endtask

    task automatic new_random_shape();
        int roll;
        int height;
        int width;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            height = $urandom_range(0, 5);
        else if (roll < 92)
            height = $urandom_range(6, 16);
        else
            height = $urandom_range(17, 48);
        roll = $urandom_range(0, 99);
        if (roll < 70)
            width = $urandom_range(0, 6);
        else if (roll < 92)
            width = $urandom_range(7, 40);
        else
            width = $urandom_range(41, 200);
        if (height * width > 600)
            height = 2;
        wait_idle();
        roll = $urandom_range(0, 2);
        if (roll != 2)
            write_reg(REG_FRAME_ROWS, CFG_DATA_W'(height));
        // upper data bits lie beyond the column register and must be dropped
        if (roll != 1)
            write_reg(REG_FRAME_COLS, {2'($urandom_range(0, 3)), 11'(width)});
    endtask

    task automatic test_single_pixel();
        send_item(MODE_DRAIN, 8'h00);
        send_item(MODE_PIXEL, 8'hff);
        send_item(MODE_PIXEL, 8'h5a);
        send_item(MODE_DRAIN, 8'hff);
        send_item(MODE_DRAIN, 8'h00);
        send_item(MODE_PIXEL, 8'h00);
        send_item(MODE_DRAIN, 8'h00);
    endtask

    task automatic test_small_frame();
        wait_idle();
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(3));
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(3));
        run_frame(0, 1'b1, 5);
        // sender holds off until the results so far have all come out
        pause_for_results();
        run_frame(0, 1'b1, -1);
    endtask

    task automatic test_register_limits();
        wait_idle();
        write_reg(REG_FRAME_ROWS, '0);
        write_reg(REG_FRAME_COLS, '0);
        run_frame(0, 1'b0, -1);
        wait_idle();
        write_reg(REG_FRAME_ROWS, '1);
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(11'h7ff));
        run_frame(0, 1'b0, 30);
        wait_idle();
        write_reg(REG_FRAME_COLS, 13'h1803);
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(4));
        run_frame(0, 1'b0, 8);
        // abandon the frame with outputs still pending
        wait_idle();
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(2));
        run_frame(20, 1'b0, -1);
        wait_idle();
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(MAX_ROWS));
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(1));
        run_frame(0, 1'b0, 40);
        wait_idle();
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(1));
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(MAX_COLS));
        run_frame(0, 1'b0, 40);
        wait_idle();
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(3));
        run_frame(0, 1'b1, 40);
    endtask

    task automatic test_back_to_back();
        int first;
        wait_idle();
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(5));
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(7));
        no_gaps = 1'b1;
        first   = items_sent;
        while (items_sent - first < 300)
            run_frame(0, 1'b0, -1);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_stream();
        int first;
        int roll;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 30)
                new_random_shape();
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                // cut the frame short; the register write throws the rest away
                run_frame(10, 1'b0, $urandom_range(1, 12));
                new_random_shape();
            end
            else
                run_frame(roll < 30 ? 15 : 0, roll > 95, -1);
            if ($urandom_range(0, 99) < 12)
                pause_for_results();
        end
    endtask

    always @(negedge clk)
        result_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        mean_rec_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_means.size() == 0)
                log_mismatch($sformatf("result %h with nothing expected", mean_value));
            else
            begin
                want = expected_means.pop_front();
                if (mean_value !== want.mean)
                    log_mismatch($sformatf("mean_value %h, expected %h", mean_value, want.mean));
                if (frame_last !== want.last)
                    log_mismatch($sformatf("frame_last %b, expected %b", frame_last, want.last));
            end
        end
    end

    // stall detector: any transaction on either channel restarts the count
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_single_pixel();
        test_small_frame();
        test_register_limits();
        test_back_to_back();
        test_random_stream();
        wait_idle();
        repeat (20) @(negedge clk);
        if (expected_means.size() != 0)
            log_mismatch("expected results never arrived");
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
